### rtl/core/rec_pkg.sv
// Package with shared types, time constants and calendar helpers for the occurrence calculator.
`timescale 1ns / 1ps

package rec_pkg;

    localparam int TIME_W = 48;
    localparam int IN_W   = 47;
    localparam int DUR_W  = 40;
    localparam int DAY_W  = 27;
    localparam int PER_W  = 30;

    localparam logic [DAY_W-1:0] DAY_MS  = 27'd86400000;
    localparam logic [PER_W-1:0] DAY_PER = 30'd86400000;
    localparam logic [PER_W-1:0] WEEK_MS = 30'd604800000;
    // 146097 days: every run of 400 Gregorian years has this many.
    localparam logic [IN_W-1:0]  ERA_MS  = 47'd12622780800000;

    // Reciprocals of the two periods scaled by 2^58. The top 32 bits of an
    // elapsed time times one of these, shifted down by 43, give a quotient
    // that is low by at most one.
    localparam logic [31:0] DAY_RCP  = 32'((64'd1 << 58) / 64'd86400000);
    localparam logic [31:0] WEEK_RCP = 32'((64'd1 << 58) / 64'd604800000);

    // Position of 1970 in the 400 and 100 year cycles.
    localparam logic [8:0] EPOCH_Y400 = 9'd370;
    localparam logic [6:0] EPOCH_Y100 = 7'd70;

    // Recurrence modes.
    localparam logic [1:0] MODE_NEVER   = 2'd0;
    localparam logic [1:0] MODE_DAILY   = 2'd1;
    localparam logic [1:0] MODE_WEEKLY  = 2'd2;
    localparam logic [1:0] MODE_MONTHLY = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_START    = 2'd0;
    localparam logic [1:0] REG_DURATION = 2'd1;
    localparam logic [1:0] REG_MODE     = 2'd2;
    localparam logic [1:0] REG_MDAY     = 2'd3;

    typedef struct packed {
        logic clear;
        logic adv_year;
        logic adv_month;
    } t_cal_ctl;

    typedef struct packed {
        logic       leap;
        logic [4:0] dim;
    } t_cal_sts;

    typedef struct packed {
        logic [TIME_W-1:0] next_start;
        logic              has_next;
        logic [TIME_W-1:0] prev_start;
        logic [TIME_W-1:0] prev_end;
        logic              has_prev;
        logic              active;
        logic              walk_overflow;
    } t_result;

    // Days in a month, months numbered from 1.
    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        logic [4:0] d;
        case (mon)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:        d = 5'd31;
            default:                   d = 5'd30;
        endcase
        return d;
    endfunction

endpackage

### rtl/core/rec_if.sv
// Valid/ready channel interfaces for queries, results and configuration writes.
`timescale 1ns / 1ps

interface rec_query_if;
    logic        valid;
    logic        ready;
    logic [46:0] query_time;
    modport source (output valid, output query_time, input ready);
    modport sink   (input valid, input query_time, output ready);
endinterface

interface rec_res_if;
    logic        valid;
    logic        ready;
    logic [47:0] next_start;
    logic        has_next;
    logic [47:0] prev_start;
    logic [47:0] prev_end;
    logic        has_prev;
    logic        active;
    logic        walk_overflow;
    modport source (output valid, output next_start, output has_next, output prev_start,
                    output prev_end, output has_prev, output active, output walk_overflow,
                    input ready);
    modport sink   (input valid, input next_start, input has_next, input prev_start,
                    input prev_end, input has_prev, input active, input walk_overflow,
                    output ready);
endinterface

interface rec_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [46:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/recurring_event_occurrence_calc.sv
// Top level of the recurring event occurrence calculator.
`timescale 1ns / 1ps

// Each query runs through one shared add/compare datapath under a small
// sequencer. A query before the start time goes straight to the output, mode
// never goes through the finish step, and daily and weekly take a reciprocal
// multiply, a product and two reduction steps. Monthly first locates the start
// month (by 400-year blocks, then years, months and days) and then walks one
// month per cycle, up to the MAX_MONTH_STEPS cap. The input is not ready while
// a query is in work; a finished result waits in an output register.
module recurring_event_occurrence_calc #(
    parameter int MAX_MONTH_STEPS = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    rec_query_if.sink        i_query,
    rec_res_if.source        o_res,
    rec_cfg_if.sink          i_cfg
);
    import rec_pkg::*;

    localparam int STEP_W = $clog2(MAX_MONTH_STEPS + 1);
    localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_MONTH_STEPS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ERA  = 4'd1;
    localparam logic [3:0] S_YEAR = 4'd2;
    localparam logic [3:0] S_MON  = 4'd3;
    localparam logic [3:0] S_DAYS = 4'd4;
    localparam logic [3:0] S_WALK = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_SUB  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;
    localparam logic [3:0] S_MUL  = 4'd10;
    localparam logic [3:0] S_RED  = 4'd11;
    localparam logic [3:0] S_FIX  = 4'd12;

    // Configuration registers.
    logic [IN_W-1:0]  r_start;
    logic [DUR_W-1:0] r_dur;
    logic [1:0]       r_mode;
    logic [4:0]       r_mday;

    logic [3:0]        r_state;
    logic [IN_W-1:0]   r_q;
    logic [IN_W-1:0]   r_rem;
    logic [PER_W-1:0]  r_r;
    logic [63:0]       r_prod;
    logic [TIME_W-1:0] r_g;
    logic [TIME_W-1:0] r_last;
    logic [STEP_W-1:0] r_steps;
    logic              r_first;
    t_result           r_res;
    t_result           r_out;
    logic              r_ov;

    t_cal_ctl cal_ctl;
    t_cal_sts cal_sts;

    logic              q_acc;
    logic              out_free;
    logic [PER_W-1:0]  per;
    logic [31:0]       rcp;
    logic [35:0]       ylen;
    logic [31:0]       mlen;
    logic [4:0]        target;
    logic [4:0]        day_clamp;
    logic [31:0]       off;
    logic [TIME_W-1:0] cur;
    logic [TIME_W-1:0] pend;

    rec_cal u_cal (
        .i_clk (i_clk),
        .i_ctl (cal_ctl),
        .o_sts (cal_sts)
    );

    assign i_cfg.ready   = 1'b1;
    assign i_query.ready = (r_state == S_IDLE);
    assign q_acc         = i_query.valid && i_query.ready;
    assign out_free      = !r_ov || o_res.ready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_dur   <= '0;
            r_mode  <= MODE_NEVER;
            r_mday  <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_START:    r_start <= i_cfg.data;
                REG_DURATION: r_dur   <= i_cfg.data[DUR_W-1:0];
                REG_MODE:     r_mode  <= i_cfg.data[1:0];
                REG_MDAY:     r_mday  <= i_cfg.data[4:0];
                default:      ;
            endcase
        end
    end

    // Shared arithmetic terms.
    assign per       = (r_mode == MODE_DAILY) ? DAY_PER : WEEK_MS;
    assign rcp       = (r_mode == MODE_DAILY) ? DAY_RCP : WEEK_RCP;
    assign ylen      = (cal_sts.leap ? 9'd366 : 9'd365) * DAY_MS;
    assign mlen      = cal_sts.dim * DAY_MS;
    assign target    = (r_mday == 5'd0) ? 5'd1 : r_mday;
    assign day_clamp = (target > cal_sts.dim) ? cal_sts.dim : target;
    assign off       = (day_clamp - 5'd1) * DAY_MS;
    assign cur       = r_first ? {1'b0, r_start} : r_g + {16'd0, off};
    assign pend      = r_res.prev_start + {8'd0, r_dur};

    // Calendar tracker control.
    always_comb begin
        cal_ctl.clear     = q_acc;
        cal_ctl.adv_year  = (r_state == S_YEAR) && (r_rem >= {11'd0, ylen});
        cal_ctl.adv_month = ((r_state == S_MON) && (r_rem >= {15'd0, mlen}))
                         || ((r_state == S_WALK) && (cur <= {1'b0, r_q})
                             && (r_steps != STEP_MAX));
    end

    // Sequencer and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (q_acc) begin
                        r_q   <= i_query.query_time;
                        r_res <= '0;
                        if (i_query.query_time < r_start) begin
                            r_res.next_start <= {1'b0, r_start};
                            r_res.has_next   <= 1'b1;
                            r_state          <= S_OUT;
                        end else if (r_mode == MODE_NEVER) begin
                            r_res.prev_start <= {1'b0, r_start};
                            r_state          <= S_FIN;
                        end else if (r_mode == MODE_MONTHLY) begin
                            r_rem   <= r_start;
                            r_state <= S_ERA;
                        end else begin
                            r_rem   <= i_query.query_time - r_start;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_ERA: begin
                    if (r_rem >= ERA_MS) begin
                        r_rem <= r_rem - ERA_MS;
                    end else begin
                        r_state <= S_YEAR;
                    end
                end
                S_YEAR: begin
                    if (r_rem >= {11'd0, ylen}) begin
                        r_rem <= r_rem - {11'd0, ylen};
                    end else begin
                        r_state <= S_MON;
                    end
                end
                S_MON: begin
                    if (r_rem >= {15'd0, mlen}) begin
                        r_rem <= r_rem - {15'd0, mlen};
                    end else begin
                        // First millisecond of the start month.
                        r_g     <= {1'b0, r_start - r_rem};
                        r_state <= S_DAYS;
                    end
                end
                S_DAYS: begin
                    if (r_rem >= {20'd0, DAY_MS}) begin
                        r_rem <= r_rem - {20'd0, DAY_MS};
                    end else begin
                        // Add back the time of day so later steps keep it.
                        r_g     <= r_g + {1'b0, r_rem};
                        r_first <= 1'b1;
                        r_steps <= '0;
                        r_last  <= {1'b0, r_start};
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (cur <= {1'b0, r_q}) begin
                        if (r_steps == STEP_MAX) begin
                            r_res.walk_overflow <= 1'b1;
                            r_res.prev_start    <= cur;
                            r_state             <= S_FIN;
                        end else begin
                            r_last  <= cur;
                            r_g     <= r_g + {16'd0, mlen};
                            r_steps <= r_steps + 1'b1;
                            r_first <= 1'b0;
                        end
                    end else begin
                        r_res.prev_start <= r_last;
                        r_res.next_start <= cur;
                        r_res.has_next   <= 1'b1;
                        r_state          <= S_FIN;
                    end
                end
                S_DIV: begin
                    // Quotient estimate from the top 32 bits of the elapsed time.
                    r_prod  <= r_rem[IN_W-1:15] * rcp;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // Whole periods covered by the estimate.
                    r_prod  <= r_prod[63:43] * per;
                    r_state <= S_RED;
                end
                S_RED: begin
                    // What is left is below two periods.
                    r_rem   <= r_rem - r_prod[IN_W-1:0];
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    if (r_rem >= {17'd0, per}) begin
                        r_r <= PER_W'(r_rem - {17'd0, per});
                    end else begin
                        r_r <= r_rem[PER_W-1:0];
                    end
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_res.prev_start <= {1'b0, r_q - {17'd0, r_r}};
                    r_state          <= S_FIN;
                end
                S_FIN: begin
                    r_res.has_prev <= 1'b1;
                    r_res.prev_end <= pend;
                    r_res.active   <= ({1'b0, r_q} < pend);
                    if ((r_mode == MODE_DAILY) || (r_mode == MODE_WEEKLY)) begin
                        r_res.next_start <= r_res.prev_start + {18'd0, per};
                        r_res.has_next   <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((r_state == S_OUT) && out_free) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.next_start    = r_out.next_start;
    assign o_res.has_next      = r_out.has_next;
    assign o_res.prev_start    = r_out.prev_start;
    assign o_res.prev_end      = r_out.prev_end;
    assign o_res.has_prev      = r_out.has_prev;
    assign o_res.active        = r_out.active;
    assign o_res.walk_overflow = r_out.walk_overflow;

    // A capped walk never reports a next occurrence.
    a_ovf_no_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !(r_out.walk_overflow && r_out.has_next))
        else $error("overflow result carries a next occurrence");

    // Nothing before the start time can be active.
    a_active_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_out.has_prev || !r_out.active))
        else $error("active without a previous occurrence");

    // The month walk stops at the cap.
    a_step_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_steps <= STEP_MAX))
        else $error("month walk ran past the step cap");

    // A result is loaded only once the output register is free.
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_res.ready) |=> r_ov)
        else $error("pending result dropped");

endmodule

### rtl/core/rec_cal.sv
// Calendar position tracker: year within the leap cycles and month of year.
`timescale 1ns / 1ps

module rec_cal (
    input  logic              i_clk,
    input  rec_pkg::t_cal_ctl i_ctl,
    output rec_pkg::t_cal_sts o_sts
);
    import rec_pkg::*;

    logic [8:0] r_y400, n_y400;
    logic [6:0] r_y100, n_y100;
    logic [3:0] r_mon, n_mon;
    logic       year_step;
    logic       leap;

    // A month step past December also moves the year.
    assign year_step = i_ctl.adv_year || (i_ctl.adv_month && (r_mon == 4'd12));

    always_comb begin
        n_y400 = r_y400;
        n_y100 = r_y100;
        n_mon  = r_mon;
        if (i_ctl.clear) begin
            n_y400 = EPOCH_Y400;
            n_y100 = EPOCH_Y100;
            n_mon  = 4'd1;
        end else begin
            if (year_step) begin
                n_y400 = (r_y400 == 9'd399) ? 9'd0 : r_y400 + 9'd1;
                n_y100 = (r_y100 == 7'd99) ? 7'd0 : r_y100 + 7'd1;
            end
            if (i_ctl.adv_month) begin
                n_mon = (r_mon == 4'd12) ? 4'd1 : r_mon + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_y400 <= n_y400;
        r_y100 <= n_y100;
        r_mon  <= n_mon;
    end

    // Gregorian rule: divisible by 4 and not by 100, or divisible by 400.
    assign leap = ((r_y400[1:0] == 2'd0) && (r_y100 != 7'd0)) || (r_y400 == 9'd0);
    assign o_sts.leap = leap;
    assign o_sts.dim  = month_days(r_mon, leap);

endmodule
